// ===== hdl/bmpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpq_pkg
// Shared constants, codes and controller/datapath interface types for the
// bounded max priority queue.
// ----------------------------------------------------------------------------
package bmpq_pkg;

   // storage geometry
   localparam int DEPTH      = 16;
   localparam int PRIO_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // port field widths
   localparam int OP_W      = 2;
   localparam int KEY_W     = 8;
   localparam int PRIO_IO_W = 32;
   localparam int STATUS_W  = 2;
   localparam int OCC_W     = 5;
   localparam int CAP_W     = 5;

   // capacity register reset value
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd12;

   // operation codes
   localparam logic [OP_W-1:0] OP_ENQ     = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQ     = 2'd1;
   localparam logic [OP_W-1:0] OP_DEQ_MAX = 2'd2;
   localparam logic [OP_W-1:0] OP_SEARCH  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   // controller -> datapath commands
   typedef struct packed {
      logic load;    // capture request beat, start a new operation
      logic scan;    // examine one stored entry
      logic commit;  // update storage and load the result register
   } ctl_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic scan_last;  // scan finished (or none needed)
      logic out_free;   // result register can take a new beat
   } dp_sts_type;

endpackage

// ===== hdl/bmpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmpq_ctrl
// Operation sequencer: accept a request, step the entry scan, then commit
// the result once the response register is free.
// ----------------------------------------------------------------------------
module bmpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bmpq_pkg::dp_sts_type sts,
   output bmpq_pkg::ctl_cmd_type cmd
);
   import bmpq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      req_stall  = 1'b1;
      case (state_ff)
         S_IDLE: begin
            // no request beat is taken while reset is held
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a blocked result holds the sequencer in place
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !sts.out_free) |=> (state_ff == S_DONE))
      else $error("sequencer left DONE while result register busy");

   // a request beat always starts a scan on the next cycle
   a_load_to_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_SCAN))
      else $error("accepted request did not enter scan");

   // commit only ever follows the scan phase
   a_commit_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> ($past(state_ff) == S_SCAN || $past(state_ff) == S_DONE))
      else $error("commit without preceding scan");

endmodule

// ===== hdl/bmpq_datapath.sv =====
// ----------------------------------------------------------------------------
// bmpq_datapath
// Entry storage (oldest at slot 0), capacity register, one-entry-per-cycle
// scan unit for max-priority and key search, and the response register.
// ----------------------------------------------------------------------------
module bmpq_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   // request payload
   input  logic [bmpq_pkg::OP_W-1:0]            req_op,
   input  logic signed [bmpq_pkg::KEY_W-1:0]    req_item_key,
   input  logic [bmpq_pkg::PRIO_IO_W-1:0]       req_item_priority,
   // capacity register write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bmpq_pkg::CAP_W-1:0]           csr_capacity,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bmpq_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [bmpq_pkg::KEY_W-1:0]    rsp_out_key,
   output logic [bmpq_pkg::PRIO_IO_W-1:0]       rsp_out_priority,
   output logic [bmpq_pkg::OCC_W-1:0]           rsp_occupancy,
   // control
   input  bmpq_pkg::ctl_cmd_type                cmd,
   output bmpq_pkg::dp_sts_type                 sts
);
   import bmpq_pkg::*;

   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // entry storage
   logic [KEY_W-1:0]      keys_ff  [DEPTH];
   logic [PRIO_WIDTH-1:0] prios_ff [DEPTH];
   logic [KEY_W-1:0]      keys_in  [DEPTH];
   logic [PRIO_WIDTH-1:0] prios_in [DEPTH];
   logic [DEPTH-1:0]      slot_we;

   // control state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] capacity_ff;
   logic             rsp_valid_ff;

   // operation registers
   logic [OP_W-1:0]       op_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [PRIO_WIDTH-1:0] prio_ff;
   logic [IDX_W-1:0]      scan_idx_ff;
   logic [IDX_W-1:0]      pick_ff;
   logic                  found_ff;
   logic [KEY_W-1:0]      best_key_ff;
   logic [PRIO_WIDTH-1:0] best_prio_ff;

   // response registers
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [KEY_W-1:0]     rkey_ff, rkey_in;
   logic [PRIO_IO_W-1:0] rprio_ff, rprio_in;
   logic [OCC_W-1:0]     occ_ff;

   // decoded conditions
   logic             is_empty;
   logic             is_full;
   logic             is_remove_op;
   logic             needs_scan;
   logic             do_remove;
   logic             do_insert;
   logic [KEY_W-1:0] cur_key;
   logic [PRIO_WIDTH-1:0] cur_prio;
   logic             take_max;
   logic             key_hit;

   assign is_empty     = (count_ff == '0);
   assign is_full      = (CMP_W'(count_ff) >= CMP_W'(capacity_ff)) ||
                         (count_ff == CNT_W'(DEPTH));
   assign is_remove_op = (op_ff inside {OP_DEQ, OP_DEQ_MAX});
   assign needs_scan   = (op_ff inside {OP_DEQ_MAX, OP_SEARCH}) && !is_empty;
   assign do_remove    = is_remove_op && !is_empty;
   assign do_insert    = (op_ff == OP_ENQ) && !is_full;

   // scan read port
   assign cur_key  = keys_ff[scan_idx_ff];
   assign cur_prio = prios_ff[scan_idx_ff];
   assign take_max = (scan_idx_ff == '0) || (cur_prio > best_prio_ff);
   assign key_hit  = (cur_key == key_ff);

   assign sts.scan_last = !needs_scan || (scan_idx_ff == IDX_W'(count_ff - CNT_W'(1)));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // capacity register, writable whenever reset is released
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_capacity;
      end
   end

   // operation capture and scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_op;
         key_ff      <= req_item_key;
         prio_ff     <= PRIO_WIDTH'(req_item_priority);
         scan_idx_ff <= '0;
         pick_ff     <= '0;
         found_ff    <= 1'b0;
      end else if (cmd.scan && needs_scan) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         if (op_ff == OP_DEQ_MAX) begin
            if (take_max) begin
               pick_ff      <= scan_idx_ff;
               best_key_ff  <= cur_key;
               best_prio_ff <= cur_prio;
            end
         end else if (key_hit) begin
            // later hits are newer entries
            found_ff     <= 1'b1;
            best_key_ff  <= cur_key;
            best_prio_ff <= cur_prio;
         end
      end
   end

   // storage update: append at count, or close the gap at pick
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         keys_in[i]  = key_ff;
         prios_in[i] = prio_ff;
         slot_we[i]  = 1'b0;
         if (cmd.commit && do_insert && (CNT_W'(i) == count_ff)) begin
            slot_we[i] = 1'b1;
         end else if (cmd.commit && do_remove && (IDX_W'(i) >= pick_ff) &&
                      (i < DEPTH - 1)) begin
            keys_in[i]  = keys_ff[(i + 1) % DEPTH];
            prios_in[i] = prios_ff[(i + 1) % DEPTH];
            slot_we[i]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (slot_we[i]) begin
            keys_ff[i]  <= keys_in[i];
            prios_ff[i] <= prios_in[i];
         end
      end
   end

   // result formation
   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      rkey_in   = '0;
      rprio_in  = '0;
      case (op_ff)
         OP_ENQ: begin
            if (is_full) begin
               status_in = ST_OVERFLOW;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DEQ: begin
            if (is_empty) begin
               status_in = ST_UNDERFLOW;
            end else begin
               rkey_in  = keys_ff[0];
               rprio_in = PRIO_IO_W'(prios_ff[0]);
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_DEQ_MAX: begin
            if (is_empty) begin
               status_in = ST_UNDERFLOW;
            end else begin
               rkey_in  = best_key_ff;
               rprio_in = PRIO_IO_W'(best_prio_ff);
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_SEARCH: begin
            if (found_ff) begin
               rkey_in  = best_key_ff;
               rprio_in = PRIO_IO_W'(best_prio_ff);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // occupancy and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         rkey_ff   <= rkey_in;
         rprio_ff  <= rprio_in;
         occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_key      = rkey_ff;
   assign rsp_out_priority = rprio_ff;
   assign rsp_occupancy    = occ_ff;

   // occupancy never exceeds storage
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // occupancy only moves on commit
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(count_ff))
      else $error("entry count changed outside commit");

   // reported occupancy matches the new entry count
   a_occ_match: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (rsp_valid_ff && (CNT_W'(occ_ff) == count_ff)))
      else $error("reported occupancy differs from entry count");

endmodule

// ===== hdl/bounded_max_priority_queue.sv =====
// rsp_valid rises once an accepted request has finished its entry scan and been committed;
//   the scan steps over each stored entry for max dequeue and search, and once for the rest.
// A new request beat is taken only after the previous result has been committed, so a
//   finished result that waits on rsp_stall also holds off the next request.
// Reset (synchronous, active high): queue empty, capacity 12, response idle;
//   entry slots are left as they are and are only read after being written.
// ----------------------------------------------------------------------------
// bounded_max_priority_queue
// Bounded unsorted priority queue of (key, priority) entries with enqueue,
// dequeue oldest, dequeue max priority and key search.
// ----------------------------------------------------------------------------
module bounded_max_priority_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bmpq_pkg::OP_W-1:0]            req_op,
   input  logic signed [bmpq_pkg::KEY_W-1:0]    req_item_key,
   input  logic [bmpq_pkg::PRIO_IO_W-1:0]       req_item_priority,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bmpq_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [bmpq_pkg::KEY_W-1:0]    rsp_out_key,
   output logic [bmpq_pkg::PRIO_IO_W-1:0]       rsp_out_priority,
   output logic [bmpq_pkg::OCC_W-1:0]           rsp_occupancy,
   // capacity register write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bmpq_pkg::CAP_W-1:0]           csr_capacity
);
   import bmpq_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // sequencer
   bmpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage, scan and response
   bmpq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_op),
      .req_item_key      (req_item_key),
      .req_item_priority (req_item_priority),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_capacity      (csr_capacity),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_occupancy     (rsp_occupancy),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule
